>>> hdl/bvtm_pkg.sv
// package for the battery voltage trimmed mean block
// widths, reset constants and the shared unit's operation codes; no dependencies
`timescale 1ns / 1ps

package bvtm_pkg;

  localparam int unsigned DATA_W         = 16;
  localparam int unsigned RING_DEPTH_DEF = 4;
  localparam int unsigned STEP_W         = $clog2(DATA_W);

  typedef logic [DATA_W-1:0] sample_t;

  localparam sample_t INVALID_MARK   = 16'hFFFF;
  localparam sample_t FALLBACK_RESET = 16'd3800;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

endpackage

>>> hdl/bvtm_if.sv
// valid/ready channel interfaces for the input and result words
// depends on bvtm_pkg
`timescale 1ns / 1ps

interface bvtm_in_if import bvtm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t first_sample;
  sample_t second_sample;

  modport source (output valid, output first_sample, output second_sample, input ready);
  modport sink (input valid, input first_sample, input second_sample, output ready);
endinterface

interface bvtm_out_if import bvtm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t filtered_voltage;

  modport source (output valid, output filtered_voltage, input ready);
  modport sink (input valid, input filtered_voltage, output ready);
endinterface

>>> hdl/battery_voltage_trimmed_mean.sv
// Battery voltage filter. Each input word carries two millivolt readings that are written in
// turn into a ring of RING_DEPTH entries (reset to 16'hFFFF, which marks an entry invalid).
// Each word gives one filtered voltage: with the ring full of valid entries, the sum less the
// largest and smallest divided by RING_DEPTH-2; with some valid, their truncated mean; with
// none, the fallback register (reset 3800, written through cfg_we_i/cfg_data_i, which the
// user must drive only while idle; the block itself does not enforce this). All arithmetic
// goes through one shared add/subtract unit under a sequencer: the writes of both readings,
// the sum, minimum and maximum steps for each valid ring entry (an invalid one is only
// checked and skipped), for a full ring the trims of the largest and the smallest, then, when
// any entry is valid, a setup step and sixteen restoring divide steps, and last the load of
// the output register, which waits while the previous result is still held and not taken.
// A finished result waits in the output register while the next word is taken.
// depends on bvtm_pkg, bvtm_if, bvtm_alu, bvtm_ring
`timescale 1ns / 1ps

module battery_voltage_trimmed_mean import bvtm_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [DATA_W-1:0] cfg_data_i,
  bvtm_in_if.sink           in_i,
  bvtm_out_if.source        out_o
);

  localparam int unsigned IDX_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_W = DATA_W + $clog2(RING_DEPTH);

  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(RING_DEPTH);
  localparam logic [CNT_W-1:0]  TRIM_DIV  = CNT_W'(RING_DEPTH - 2);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR2,
    ST_ADD,
    ST_LO,
    ST_HI,
    ST_TRIM_HI,
    ST_TRIM_LO,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e            state_q;
  logic [IDX_W-1:0]  wpos_q;
  logic [IDX_W-1:0]  idx_q;
  sample_t           second_q;
  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  cnt_q;
  sample_t           lo_q;
  sample_t           hi_q;
  logic [CNT_W-1:0]  div_q;
  logic [CNT_W-1:0]  rem_q;
  sample_t           quot_q;
  logic [STEP_W-1:0] step_q;
  sample_t           fallback_q;
  sample_t           fallback_d;
  logic              out_vld_q;
  sample_t           out_data_q;

  logic              in_acc;
  logic              ring_we;
  sample_t           ring_wdata;
  sample_t           rd_data;
  logic              rd_valid;
  alu_op_e           alu_op;
  logic [SUM_W-1:0]  alu_a;
  logic [SUM_W-1:0]  alu_b;
  logic [SUM_W-1:0]  alu_res;
  logic              alu_borrow;
  state_e            scan_next;
  logic [CNT_W-1:0]  scan_div;
  logic [IDX_W-1:0]  wpos_inc;
  logic [IDX_W-1:0]  idx_inc;

  assign in_acc     = in_i.valid & in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_o.valid            = out_vld_q;
  assign out_o.filtered_voltage = out_data_q;

  assign ring_we    = in_acc | (state_q == ST_WR2);
  assign ring_wdata = (state_q == ST_IDLE) ? in_i.first_sample : second_q;
  assign rd_valid   = (rd_data != INVALID_MARK);

  assign wpos_inc = (wpos_q == LAST_IDX) ? '0 : wpos_q + 1'b1;
  assign idx_inc  = idx_q + 1'b1;

  bvtm_ring #(
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (ring_we),
    .wr_idx_i  (wpos_q),
    .wr_data_i (ring_wdata),
    .rd_idx_i  (idx_q),
    .rd_data_o (rd_data)
  );

  bvtm_alu #(
    .W (SUM_W)
  ) u_alu (
    .op_i     (alu_op),
    .a_i      (alu_a),
    .b_i      (alu_b),
    .res_o    (alu_res),
    .borrow_o (alu_borrow)
  );

  // operand selection for the shared unit
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = sum_q;
    alu_b  = '0;
    unique case (state_q)
      ST_ADD: begin
        alu_b = SUM_W'(rd_data);
      end
      ST_LO: begin
        alu_op = ALU_SUB;
        alu_a  = SUM_W'(rd_data);
        alu_b  = SUM_W'(lo_q);
      end
      ST_HI: begin
        alu_op = ALU_SUB;
        alu_a  = SUM_W'(hi_q);
        alu_b  = SUM_W'(rd_data);
      end
      ST_TRIM_HI: begin
        alu_op = ALU_SUB;
        alu_b  = SUM_W'(hi_q);
      end
      ST_TRIM_LO: begin
        alu_op = ALU_SUB;
        alu_b  = SUM_W'(lo_q);
      end
      ST_DIV: begin
        // shifted partial remainder against the divisor
        alu_op = ALU_SUB;
        alu_a  = SUM_W'({rem_q, quot_q[DATA_W-1]});
        alu_b  = SUM_W'(div_q);
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  // where the sequencer goes once the last entry has been scanned
  always_comb begin
    scan_div = cnt_q;
    if (cnt_q == '0) begin
      scan_next = ST_OUT;
    end else if (cnt_q == FULL_CNT) begin
      scan_next = ST_TRIM_HI;
      scan_div  = TRIM_DIV;
    end else begin
      scan_next = ST_PREP;
    end
  end

  assign fallback_d = cfg_we_i ? cfg_data_i : fallback_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fallback_q <= FALLBACK_RESET;
    end else begin
      fallback_q <= fallback_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      wpos_q     <= '0;
      idx_q      <= '0;
      second_q   <= '0;
      sum_q      <= '0;
      cnt_q      <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
      div_q      <= '0;
      rem_q      <= '0;
      quot_q     <= '0;
      step_q     <= '0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
    end else begin
      // the output stage sets valid itself when it loads
      if (out_vld_q && out_o.ready && (state_q != ST_OUT)) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            second_q <= in_i.second_sample;
            wpos_q   <= wpos_inc;
            state_q  <= ST_WR2;
          end
        end
        ST_WR2: begin
          wpos_q  <= wpos_inc;
          idx_q   <= '0;
          sum_q   <= '0;
          cnt_q   <= '0;
          lo_q    <= INVALID_MARK;
          hi_q    <= '0;
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          if (rd_valid) begin
            sum_q   <= alu_res;
            cnt_q   <= cnt_q + 1'b1;
            state_q <= ST_LO;
          end else if (idx_q == LAST_IDX) begin
            div_q   <= scan_div;
            quot_q  <= fallback_q;
            state_q <= scan_next;
          end else begin
            idx_q <= idx_inc;
          end
        end
        ST_LO: begin
          if (alu_borrow) begin
            lo_q <= rd_data;
          end
          state_q <= ST_HI;
        end
        ST_HI: begin
          if (alu_borrow) begin
            hi_q <= rd_data;
          end
          if (idx_q == LAST_IDX) begin
            div_q   <= scan_div;
            quot_q  <= fallback_q;
            state_q <= scan_next;
          end else begin
            idx_q   <= idx_inc;
            state_q <= ST_ADD;
          end
        end
        ST_TRIM_HI: begin
          sum_q   <= alu_res;
          state_q <= ST_TRIM_LO;
        end
        ST_TRIM_LO: begin
          sum_q   <= alu_res;
          state_q <= ST_PREP;
        end
        ST_PREP: begin
          // quotient fits 16 bits, so the upper part is already below the divisor
          rem_q   <= CNT_W'(sum_q >> DATA_W);
          quot_q  <= sum_q[DATA_W-1:0];
          step_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          quot_q <= {quot_q[DATA_W-2:0], ~alu_borrow};
          if (alu_borrow) begin
            rem_q <= {rem_q[CNT_W-2:0], quot_q[DATA_W-1]};
          end else begin
            rem_q <= alu_res[CNT_W-1:0];
          end
          step_q <= step_q + 1'b1;
          if (step_q == LAST_STEP) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_vld_q || out_o.ready) begin
            out_data_q <= quot_q;
            out_vld_q  <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/bvtm_alu.sv
// shared add/subtract unit, used for accumulation, compares, trims and divide steps
// depends on bvtm_pkg
`timescale 1ns / 1ps

module bvtm_alu import bvtm_pkg::*; #(
  parameter int unsigned W = 18
) (
  input  alu_op_e        op_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [W-1:0]   res_o,
  output logic           borrow_o
);

  logic         sub;
  logic [W-1:0] b_x;
  logic [W:0]   full;

  assign sub  = (op_i == ALU_SUB);
  assign b_x  = sub ? ~b_i : b_i;
  // single adder: subtraction as a + ~b + 1, carry out low means borrow
  assign full = {1'b0, a_i} + {1'b0, b_x} + (W+1)'(sub);

  assign res_o    = full[W-1:0];
  assign borrow_o = sub & ~full[W];

endmodule

>>> hdl/bvtm_ring.sv
// sample ring storage, one write port and one read port
// depends on bvtm_pkg
`timescale 1ns / 1ps

module bvtm_ring import bvtm_pkg::*; #(
  parameter int unsigned DEPTH = RING_DEPTH_DEF,
  localparam int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_idx_i,
  input  sample_t          wr_data_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output sample_t          rd_data_o
);

  sample_t ring_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        ring_q[i] <= INVALID_MARK;
      end
    end else if (wr_en_i) begin
      ring_q[wr_idx_i] <= wr_data_i;
    end
  end

  assign rd_data_o = ring_q[rd_idx_i];

endmodule

>>> hdl/bvtm_checker.sv
// port-level checks for the battery voltage filter, bound to the top level
// depends on bvtm_pkg and battery_voltage_trimmed_mean
`timescale 1ns / 1ps

module bvtm_checker import bvtm_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [DATA_W-1:0] out_data_i
);

  // one word at a time: no accept right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready right after an accepted word");

  // a result needs the whole sequence, never appears the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !$rose(out_valid_i))
    else $error("result appeared one cycle after accept");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(out_data_i))
    else $error("result word changed while stalled");

endmodule

bind battery_voltage_trimmed_mean bvtm_checker u_bvtm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.filtered_voltage)
);
